// File: src/ray_refract_reflect_2d_core_assert.svh
// Assertion macros shared by the checker of the refraction core.
`ifndef RAY_REFRACT_REFLECT_2D_CORE_ASSERT_SVH
`define RAY_REFRACT_REFLECT_2D_CORE_ASSERT_SVH

// A property checked at every rising clock edge outside reset.
`define RRR_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// A signal that must stay stable in the cycle after a condition is seen.
`define RRR_ASSERT_HOLD(label, cond, sig, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) \
    (cond) |=> $stable(sig)) else $error(msg);

`endif

// File: src/rrr_pkg.sv
// Shared constants and helper functions of the refraction core.
package rrr_pkg;

  localparam int unsigned VECTOR_WIDTH_DEF = 32;
  localparam int unsigned IDX_W = 16;
  localparam int unsigned UNIT_W = 32;
  localparam int unsigned NORM_W = 30;
  localparam int unsigned LEN_W = 31;
  localparam int unsigned NUM_W = 2 * NORM_W + 1;
  localparam int unsigned QUO_W = 31;
  localparam int unsigned NORM_LAT = 5 + LEN_W + 1 + QUO_W + 1;
  localparam int unsigned V2_W = 40;
  localparam int unsigned DISC_W = 58;

  // Right shift with rounding to nearest, halves away from zero.
  function automatic logic signed [65:0] rsh_round(input logic signed [65:0] v,
                                                   input int unsigned s);
    logic [65:0] mag;
    logic [65:0] r;
    mag = v[65] ? 66'(-v) : 66'(v);
    r = (mag + (66'd1 << (s - 1))) >> s;
    return v[65] ? -$signed(r) : $signed(r);
  endfunction

endpackage

// File: src/rrr_delay.sv
// Enabled shift register that carries side data alongside a pipelined unit.
module rrr_delay #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 1
) (
  input  logic             clk_i,
  input  logic             en_i,
  input  logic [WIDTH-1:0] d_i,
  output logic [WIDTH-1:0] q_o
);

  logic [WIDTH-1:0] data_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data_q[0] <= d_i;
      for (int i = 1; i < DEPTH; i++) begin
        data_q[i] <= data_q[i-1];
      end
    end
  end

  assign q_o = data_q[DEPTH-1];

endmodule

// File: src/rrr_isqrt.sv
// Pipelined integer square root, one root bit per stage.
module rrr_isqrt #(
  parameter int unsigned IN_W = 58
) (
  input  logic                    clk_i,
  input  logic                    en_i,
  input  logic [IN_W-1:0]         v_i,
  output logic [(IN_W+1)/2-1:0]   root_o
);

  localparam int unsigned RW = (IN_W + 1) / 2;
  localparam int unsigned REM_W = RW + 3;

  logic [REM_W-1:0] rem_s [RW+1];
  logic [RW-1:0]    r_s   [RW+1];
  logic [2*RW-1:0]  v_s   [RW+1];

  assign rem_s[0] = '0;
  assign r_s[0]   = '0;
  assign v_s[0]   = (2*RW)'(v_i);

  for (genvar k = 0; k < RW; k++) begin : g_stage
    logic [REM_W-1:0] rem_t;
    logic [REM_W-1:0] trial;
    logic [REM_W-1:0] rem_d, rem_q;
    logic [RW-1:0]    r_d, r_q;
    logic [2*RW-1:0]  v_q;

    always_comb begin
      rem_t = {rem_s[k][REM_W-3:0], v_s[k][2*RW-1 -: 2]};
      trial = REM_W'({r_s[k], 2'b01});
      if (rem_t >= trial) begin
        rem_d = rem_t - trial;
        r_d   = {r_s[k][RW-2:0], 1'b1};
      end else begin
        rem_d = rem_t;
        r_d   = {r_s[k][RW-2:0], 1'b0};
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q <= rem_d;
        r_q   <= r_d;
        v_q   <= {v_s[k][2*RW-3:0], 2'b00};
      end
    end

    assign rem_s[k+1] = rem_q;
    assign r_s[k+1]   = r_q;
    assign v_s[k+1]   = v_q;
  end

  assign root_o = r_s[RW];

endmodule

// File: src/rrr_div.sv
// Pipelined restoring divider, one quotient bit per stage.
module rrr_div #(
  parameter int unsigned NW = 61,
  parameter int unsigned DW = 31,
  parameter int unsigned QW = 31
) (
  input  logic          clk_i,
  input  logic          en_i,
  input  logic [NW-1:0] num_i,
  input  logic [DW-1:0] den_i,
  output logic [QW-1:0] quo_o
);

  logic [DW:0]   rem_s [QW+1];
  logic [QW-1:0] n_s   [QW+1];
  logic [QW-1:0] q_s   [QW+1];
  logic [DW-1:0] d_s   [QW+1];

  // The quotient fits in QW bits, so the top bits of the dividend start as remainder.
  assign rem_s[0] = (DW+1)'(num_i[NW-1:QW]);
  assign n_s[0]   = num_i[QW-1:0];
  assign q_s[0]   = '0;
  assign d_s[0]   = den_i;

  for (genvar k = 0; k < QW; k++) begin : g_stage
    logic [DW:0]   rem_t;
    logic [DW:0]   rem_d, rem_q;
    logic [QW-1:0] q_d, q_q;
    logic [QW-1:0] n_q;
    logic [DW-1:0] d_q;

    always_comb begin
      rem_t = {rem_s[k][DW-1:0], n_s[k][QW-1]};
      if (rem_t >= {1'b0, d_s[k]}) begin
        rem_d = rem_t - {1'b0, d_s[k]};
        q_d   = {q_s[k][QW-2:0], 1'b1};
      end else begin
        rem_d = rem_t;
        q_d   = {q_s[k][QW-2:0], 1'b0};
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q <= rem_d;
        q_q   <= q_d;
        n_q   <= {n_s[k][QW-2:0], 1'b0};
        d_q   <= d_s[k];
      end
    end

    assign rem_s[k+1] = rem_q;
    assign q_s[k+1]   = q_q;
    assign n_s[k+1]   = n_q;
    assign d_s[k+1]   = d_q;
  end

  assign quo_o = q_s[QW];

endmodule

// File: src/rrr_norm.sv
// Pipelined vector normalizer giving a signed Q2.30 unit vector.
module rrr_norm #(
  parameter int unsigned IW = 32
) (
  input  logic                                clk_i,
  input  logic                                en_i,
  input  logic signed [IW-1:0]                x_i,
  input  logic signed [IW-1:0]                y_i,
  output logic signed [rrr_pkg::UNIT_W-1:0]   ux_o,
  output logic signed [rrr_pkg::UNIT_W-1:0]   uy_o,
  output logic                                zero_o
);

  localparam int unsigned PW = $clog2(IW);
  localparam int unsigned EW = IW + rrr_pkg::NORM_W;
  localparam int unsigned NW = rrr_pkg::NORM_W;
  localparam int unsigned LW = rrr_pkg::LEN_W;
  localparam int unsigned SIDE_W = 2 * NW + 3;

  // Stage 1: magnitudes and the larger one.
  logic [IW-1:0] ax1_q, ay1_q, m1_q;
  logic          sx1_q, sy1_q, z1_q;
  logic [IW-1:0] ax1_d, ay1_d;

  assign ax1_d = x_i[IW-1] ? (~x_i + 1'b1) : x_i;
  assign ay1_d = y_i[IW-1] ? (~y_i + 1'b1) : y_i;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ax1_q <= ax1_d;
      ay1_q <= ay1_d;
      m1_q  <= (ax1_d > ay1_d) ? ax1_d : ay1_d;
      sx1_q <= x_i[IW-1];
      sy1_q <= y_i[IW-1];
      z1_q  <= (x_i == '0) && (y_i == '0);
    end
  end

  // Stage 2: position of the leading one.
  logic [PW-1:0] pos_d, pos2_q;
  logic [IW-1:0] ax2_q, ay2_q;
  logic          sx2_q, sy2_q, z2_q;

  always_comb begin
    pos_d = '0;
    for (int i = 0; i < IW; i++) begin
      if (m1_q[i]) pos_d = PW'(i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pos2_q <= pos_d;
      ax2_q  <= ax1_q;
      ay2_q  <= ay1_q;
      sx2_q  <= sx1_q;
      sy2_q  <= sy1_q;
      z2_q   <= z1_q;
    end
  end

  // Stage 3: shift so the larger magnitude lies in [2^29, 2^30).
  logic [EW-1:0] ex_d, ey_d;
  logic [NW-1:0] ax3_q, ay3_q;
  logic          sx3_q, sy3_q, z3_q;

  always_comb begin
    int sh;
    sh = int'(pos2_q) - (int'(NW) - 1);
    if (sh >= 0) begin
      ex_d = {{NW{1'b0}}, ax2_q} >> sh;
      ey_d = {{NW{1'b0}}, ay2_q} >> sh;
    end else begin
      ex_d = {{NW{1'b0}}, ax2_q} << (-sh);
      ey_d = {{NW{1'b0}}, ay2_q} << (-sh);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ax3_q <= ex_d[NW-1:0];
      ay3_q <= ey_d[NW-1:0];
      sx3_q <= sx2_q;
      sy3_q <= sy2_q;
      z3_q  <= z2_q;
    end
  end

  // Stages 4 and 5: squares, then their sum.
  logic [2*NW-1:0] sqx4_q, sqy4_q;
  logic [NW-1:0]   ax4_q, ay4_q, ax5_q, ay5_q;
  logic            sx4_q, sy4_q, z4_q, sx5_q, sy5_q, z5_q;
  logic [2*NW:0]   sum5_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sqx4_q <= ax3_q * ax3_q;
      sqy4_q <= ay3_q * ay3_q;
      ax4_q  <= ax3_q;
      ay4_q  <= ay3_q;
      sx4_q  <= sx3_q;
      sy4_q  <= sy3_q;
      z4_q   <= z3_q;
      sum5_q <= {1'b0, sqx4_q} + {1'b0, sqy4_q};
      ax5_q  <= ax4_q;
      ay5_q  <= ay4_q;
      sx5_q  <= sx4_q;
      sy5_q  <= sy4_q;
      z5_q   <= z4_q;
    end
  end

  // Length by square root, side data delayed to match.
  logic [LW-1:0]     len;
  logic [SIDE_W-1:0] side_a;
  logic [NW-1:0]     axa, aya;
  logic              sxa, sya, za;

  rrr_isqrt #(.IN_W(2 * NW + 1)) u_len (
    .clk_i  (clk_i),
    .en_i   (en_i),
    .v_i    (sum5_q),
    .root_o (len)
  );

  rrr_delay #(.WIDTH(SIDE_W), .DEPTH(LW)) u_side_a (
    .clk_i (clk_i),
    .en_i  (en_i),
    .d_i   ({ax5_q, ay5_q, sx5_q, sy5_q, z5_q}),
    .q_o   (side_a)
  );

  assign {axa, aya, sxa, sya, za} = side_a;

  // Stage 6: rounded dividends.
  logic [rrr_pkg::NUM_W-1:0] numx6_q, numy6_q;
  logic [LW-1:0]             len6_q;
  logic                      sx6_q, sy6_q, z6_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      numx6_q <= {1'b0, axa, {NW{1'b0}}} + rrr_pkg::NUM_W'(len >> 1);
      numy6_q <= {1'b0, aya, {NW{1'b0}}} + rrr_pkg::NUM_W'(len >> 1);
      len6_q  <= len;
      sx6_q   <= sxa;
      sy6_q   <= sya;
      z6_q    <= za;
    end
  end

  logic [rrr_pkg::QUO_W-1:0] qx, qy;
  logic                      sxb, syb, zb;

  rrr_div #(.NW(rrr_pkg::NUM_W), .DW(LW), .QW(rrr_pkg::QUO_W)) u_div_x (
    .clk_i (clk_i),
    .en_i  (en_i),
    .num_i (numx6_q),
    .den_i (len6_q),
    .quo_o (qx)
  );

  rrr_div #(.NW(rrr_pkg::NUM_W), .DW(LW), .QW(rrr_pkg::QUO_W)) u_div_y (
    .clk_i (clk_i),
    .en_i  (en_i),
    .num_i (numy6_q),
    .den_i (len6_q),
    .quo_o (qy)
  );

  rrr_delay #(.WIDTH(3), .DEPTH(rrr_pkg::QUO_W)) u_side_b (
    .clk_i (clk_i),
    .en_i  (en_i),
    .d_i   ({sx6_q, sy6_q, z6_q}),
    .q_o   ({sxb, syb, zb})
  );

  // Stage 7: signs restored.
  logic signed [rrr_pkg::UNIT_W-1:0] ux7_q, uy7_q;
  logic                              z7_q;
  logic [rrr_pkg::UNIT_W-1:0]        qx_ext, qy_ext;

  assign qx_ext = rrr_pkg::UNIT_W'(qx);
  assign qy_ext = rrr_pkg::UNIT_W'(qy);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ux7_q <= sxb ? -$signed(qx_ext) : $signed(qx_ext);
      uy7_q <= syb ? -$signed(qy_ext) : $signed(qy_ext);
      z7_q  <= zb;
    end
  end

  assign ux_o   = ux7_q;
  assign uy_o   = uy7_q;
  assign zero_o = z7_q;

endmodule

// File: src/ray_refract_reflect_2d_core.sv
// Top level of the 2D refraction and reflection pipeline.
//
// The input channel (in_valid_i / in_ready_o) takes one item per cycle while
// in_ready_o is high: an incident vector, a surface normal (signed Q16.16) and
// the refractive indices of both media (unsigned Q4.12). The output channel
// (out_valid_o / out_ready_i) returns one item for each input item, in order:
// the unit deflected direction in Q16.16 and the reflected and degenerate
// flags. Both vectors are normalized, the normal is optionally turned to face
// the ray, Snell's law is applied in vector form, and the result is normalized.
// The pipeline accepts one item every cycle unless stalled. Each normalizer is
// built from bit-per-stage square root and divider chains, and the discriminant
// root adds 29 more stages.
// The whole pipeline advances together: while an output item waits and the
// receiver holds out_ready_i low, every stage holds and in_ready_o is low, so
// nothing is lost or repeated. Reset clears the valid bits of all stages and
// sets orient_normal to 1. The user must write orient_normal through cfg_we_i
// only while the pipeline is empty; the block itself does not enforce this.
module ray_refract_reflect_2d_core #(
  parameter int unsigned VECTOR_WIDTH = rrr_pkg::VECTOR_WIDTH_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic                              cfg_wdata_i,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic signed [VECTOR_WIDTH-1:0]    inc_x_i,
  input  logic signed [VECTOR_WIDTH-1:0]    inc_y_i,
  input  logic signed [VECTOR_WIDTH-1:0]    norm_x_i,
  input  logic signed [VECTOR_WIDTH-1:0]    norm_y_i,
  input  logic [rrr_pkg::IDX_W-1:0]         index_in_i,
  input  logic [rrr_pkg::IDX_W-1:0]         index_out_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic signed [VECTOR_WIDTH-1:0]    out_x_o,
  output logic signed [VECTOR_WIDTH-1:0]    out_y_o,
  output logic                              reflected_o,
  output logic                              degenerate_o
);

  localparam int unsigned W = VECTOR_WIDTH;
  localparam int unsigned XW = rrr_pkg::IDX_W;
  localparam int unsigned UW = rrr_pkg::UNIT_W;
  localparam int unsigned DISC_RW = (rrr_pkg::DISC_W + 1) / 2;
  localparam int unsigned LAT = 2 * rrr_pkg::NORM_LAT + 11 + DISC_RW;
  localparam int unsigned A_W = 2 * W + 2 * XW;
  localparam int unsigned B_W = 32 + 1 + 2 * UW + 2 * 36 + 1 + 2 * W;
  localparam int unsigned C_W = 2 + 2 * W;

  // Configuration register.
  logic cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= 1'b1;
    end else if (cfg_we_i) begin
      cfg_q <= cfg_wdata_i;
    end
  end

  // Every stage moves when the output register is free or being emptied.
  logic           en;
  logic [LAT-1:0] valid_q;

  assign en         = !valid_q[LAT-1] || out_ready_i;
  assign in_ready_o = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (en) begin
      valid_q <= {valid_q[LAT-2:0], in_valid_i};
    end
  end

  // Unit incident and normal directions.
  logic signed [UW-1:0] dx, dy, mx, my;
  logic                 zi, zn;

  rrr_norm #(.IW(W)) u_norm_inc (
    .clk_i  (clk_i),
    .en_i   (en),
    .x_i    (inc_x_i),
    .y_i    (inc_y_i),
    .ux_o   (dx),
    .uy_o   (dy),
    .zero_o (zi)
  );

  rrr_norm #(.IW(W)) u_norm_nrm (
    .clk_i  (clk_i),
    .en_i   (en),
    .x_i    (norm_x_i),
    .y_i    (norm_y_i),
    .ux_o   (mx),
    .uy_o   (my),
    .zero_o (zn)
  );

  logic signed [W-1:0] a_ix, a_iy;
  logic [XW-1:0]       a_n1, a_n2;

  rrr_delay #(.WIDTH(A_W), .DEPTH(rrr_pkg::NORM_LAT)) u_dly_a (
    .clk_i (clk_i),
    .en_i  (en),
    .d_i   ({inc_x_i, inc_y_i, index_in_i, index_out_i}),
    .q_o   ({a_ix, a_iy, a_n1, a_n2})
  );

  // Stage C1: products for the projection.
  logic signed [63:0]   c1_pxm_q, c1_pym_q;
  logic signed [UW-1:0] c1_dx_q, c1_dy_q, c1_mx_q, c1_my_q;
  logic [XW-1:0]        c1_n1_q, c1_n2_q;
  logic signed [W-1:0]  c1_ix_q, c1_iy_q;
  logic                 c1_dg_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      c1_pxm_q <= dx * mx;
      c1_pym_q <= dy * my;
      c1_dx_q  <= dx;
      c1_dy_q  <= dy;
      c1_mx_q  <= mx;
      c1_my_q  <= my;
      c1_n1_q  <= a_n1;
      c1_n2_q  <= a_n2;
      c1_ix_q  <= a_ix;
      c1_iy_q  <= a_iy;
      c1_dg_q  <= zi || zn;
    end
  end

  // Stage C2: dot product, normal orientation, scaled incident direction.
  logic signed [64:0]   c2_dot_d, c2_dot_q;
  logic                 c2_flip;
  logic signed [UW-1:0] c2_mx_q, c2_my_q;
  logic signed [48:0]   c2_pdx_q, c2_pdy_q;
  logic [2*XW-1:0]      c2_n1sq_q, c2_n2sq_q;
  logic                 c2_eq_q, c2_dg_q;
  logic [XW-1:0]        c2_n1_q;
  logic signed [W-1:0]  c2_ix_q, c2_iy_q;

  assign c2_dot_d = 65'(c1_pxm_q) + 65'(c1_pym_q);
  assign c2_flip  = cfg_q && c2_dot_d[64];

  always_ff @(posedge clk_i) begin
    if (en) begin
      c2_dot_q  <= c2_flip ? -c2_dot_d : c2_dot_d;
      c2_mx_q   <= c2_flip ? -c1_mx_q : c1_mx_q;
      c2_my_q   <= c2_flip ? -c1_my_q : c1_my_q;
      c2_pdx_q  <= c1_dx_q * $signed({1'b0, c1_n1_q});
      c2_pdy_q  <= c1_dy_q * $signed({1'b0, c1_n1_q});
      c2_n1sq_q <= c1_n1_q * c1_n1_q;
      c2_n2sq_q <= c1_n2_q * c1_n2_q;
      c2_eq_q   <= c1_n1_q == c1_n2_q;
      c2_n1_q   <= c1_n1_q;
      c2_ix_q   <= c1_ix_q;
      c2_iy_q   <= c1_iy_q;
      c2_dg_q   <= c1_dg_q;
    end
  end

  // Stage C3: rounding to Q.30, difference of the squared indices.
  logic signed [65:0]   c3_d30_r, c3_v1x_r, c3_v1y_r;
  logic signed [35:0]   c3_d30_q, c3_v1x_q, c3_v1y_q;
  logic signed [32:0]   c3_dd_q;
  logic                 c3_eq_q, c3_dg_q;
  logic [XW-1:0]        c3_n1_q;
  logic signed [UW-1:0] c3_mx_q, c3_my_q;
  logic signed [W-1:0]  c3_ix_q, c3_iy_q;

  assign c3_d30_r = rrr_pkg::rsh_round(66'(c2_dot_q), 30);
  assign c3_v1x_r = rrr_pkg::rsh_round(66'(c2_pdx_q), 12);
  assign c3_v1y_r = rrr_pkg::rsh_round(66'(c2_pdy_q), 12);

  always_ff @(posedge clk_i) begin
    if (en) begin
      c3_d30_q <= c3_d30_r[35:0];
      c3_v1x_q <= c3_v1x_r[35:0];
      c3_v1y_q <= c3_v1y_r[35:0];
      c3_dd_q  <= $signed({1'b0, c2_n1sq_q}) - $signed({1'b0, c2_n2sq_q});
      c3_eq_q  <= c2_eq_q;
      c3_n1_q  <= c2_n1_q;
      c3_mx_q  <= c2_mx_q;
      c3_my_q  <= c2_my_q;
      c3_ix_q  <= c2_ix_q;
      c3_iy_q  <= c2_iy_q;
      c3_dg_q  <= c2_dg_q;
    end
  end

  // Stages C4 to C7: projection f, its square, and the discriminant.
  logic signed [52:0]   c4_fp_q;
  logic signed [35:0]   c4_v1x_q, c4_v1y_q, c5_v1x_q, c5_v1y_q, c6_v1x_q, c6_v1y_q;
  logic signed [35:0]   c7_v1x_q, c7_v1y_q;
  logic signed [32:0]   c4_dd_q, c5_dd_q;
  logic                 c4_eq_q, c5_eq_q, c6_eq_q;
  logic                 c4_dg_q, c5_dg_q, c6_dg_q, c7_dg_q;
  logic signed [UW-1:0] c4_mx_q, c4_my_q, c5_mx_q, c5_my_q, c6_mx_q, c6_my_q;
  logic signed [UW-1:0] c7_mx_q, c7_my_q;
  logic signed [W-1:0]  c4_ix_q, c4_iy_q, c5_ix_q, c5_iy_q, c6_ix_q, c6_iy_q;
  logic signed [W-1:0]  c7_ix_q, c7_iy_q;
  logic signed [65:0]   c5_f_r;
  logic signed [31:0]   c5_f_q, c6_f_q, c7_f_q;
  logic signed [63:0]   c6_f2_q;
  logic signed [56:0]   c6_d48_q;
  logic                 c7_refl_q;
  logic [rrr_pkg::DISC_W-1:0] c7_disc_q;
  logic signed [63:0]   c7_diff;

  assign c5_f_r  = rrr_pkg::rsh_round(66'(c4_fp_q), 18);
  assign c7_diff = c6_f2_q - 64'(c6_d48_q);

  always_ff @(posedge clk_i) begin
    if (en) begin
      c4_fp_q   <= c3_d30_q * $signed({1'b0, c3_n1_q});
      c4_v1x_q  <= c3_v1x_q;
      c4_v1y_q  <= c3_v1y_q;
      c4_dd_q   <= c3_dd_q;
      c4_eq_q   <= c3_eq_q;
      c4_mx_q   <= c3_mx_q;
      c4_my_q   <= c3_my_q;
      c4_ix_q   <= c3_ix_q;
      c4_iy_q   <= c3_iy_q;
      c4_dg_q   <= c3_dg_q;

      c5_f_q    <= c5_f_r[31:0];
      c5_v1x_q  <= c4_v1x_q;
      c5_v1y_q  <= c4_v1y_q;
      c5_dd_q   <= c4_dd_q;
      c5_eq_q   <= c4_eq_q;
      c5_mx_q   <= c4_mx_q;
      c5_my_q   <= c4_my_q;
      c5_ix_q   <= c4_ix_q;
      c5_iy_q   <= c4_iy_q;
      c5_dg_q   <= c4_dg_q;

      c6_f2_q   <= c5_f_q * c5_f_q;
      c6_d48_q  <= 57'(c5_dd_q) <<< 24;
      c6_f_q    <= c5_f_q;
      c6_v1x_q  <= c5_v1x_q;
      c6_v1y_q  <= c5_v1y_q;
      c6_eq_q   <= c5_eq_q;
      c6_mx_q   <= c5_mx_q;
      c6_my_q   <= c5_my_q;
      c6_ix_q   <= c5_ix_q;
      c6_iy_q   <= c5_iy_q;
      c6_dg_q   <= c5_dg_q;

      // Equal indices and total internal reflection both reflect.
      c7_refl_q <= c6_eq_q || (64'(c6_d48_q) > c6_f2_q);
      c7_disc_q <= c7_diff[rrr_pkg::DISC_W-1:0];
      c7_f_q    <= c6_f_q;
      c7_v1x_q  <= c6_v1x_q;
      c7_v1y_q  <= c6_v1y_q;
      c7_mx_q   <= c6_mx_q;
      c7_my_q   <= c6_my_q;
      c7_ix_q   <= c6_ix_q;
      c7_iy_q   <= c6_iy_q;
      c7_dg_q   <= c6_dg_q;
    end
  end

  // Square root of the discriminant, side data delayed alongside.
  logic [DISC_RW-1:0]   root;
  logic signed [31:0]   b_f;
  logic                 b_refl, b_dg;
  logic signed [UW-1:0] b_mx, b_my;
  logic signed [35:0]   b_v1x, b_v1y;
  logic signed [W-1:0]  b_ix, b_iy;

  rrr_isqrt #(.IN_W(rrr_pkg::DISC_W)) u_disc_root (
    .clk_i  (clk_i),
    .en_i   (en),
    .v_i    (c7_disc_q),
    .root_o (root)
  );

  rrr_delay #(.WIDTH(B_W), .DEPTH(DISC_RW)) u_dly_b (
    .clk_i (clk_i),
    .en_i  (en),
    .d_i   ({c7_f_q, c7_refl_q, c7_mx_q, c7_my_q, c7_v1x_q, c7_v1y_q, c7_dg_q,
             c7_ix_q, c7_iy_q}),
    .q_o   ({b_f, b_refl, b_mx, b_my, b_v1x, b_v1y, b_dg, b_ix, b_iy})
  );

  // Stages C8 to C10: coefficient, its product with the normal, new vector.
  logic signed [31:0]   c8_coef_q;
  logic signed [UW-1:0] c8_mx_q, c8_my_q;
  logic signed [35:0]   c8_v1x_q, c8_v1y_q, c9_v1x_q, c9_v1y_q;
  logic                 c8_refl_q, c9_refl_q, c10_refl_q;
  logic                 c8_dg_q, c9_dg_q, c10_dg_q;
  logic signed [W-1:0]  c8_ix_q, c8_iy_q, c9_ix_q, c9_iy_q, c10_ix_q, c10_iy_q;
  logic signed [63:0]   c9_pcx_q, c9_pcy_q;
  logic signed [65:0]   c10_tx_r, c10_ty_r;
  logic signed [rrr_pkg::V2_W-1:0] c10_v2x_q, c10_v2y_q;

  assign c10_tx_r = rrr_pkg::rsh_round(66'(c9_pcx_q), 24);
  assign c10_ty_r = rrr_pkg::rsh_round(66'(c9_pcy_q), 24);

  always_ff @(posedge clk_i) begin
    if (en) begin
      c8_coef_q  <= b_refl ? -(b_f <<< 1) : ($signed(32'(root)) - b_f);
      c8_mx_q    <= b_mx;
      c8_my_q    <= b_my;
      c8_v1x_q   <= b_v1x;
      c8_v1y_q   <= b_v1y;
      c8_refl_q  <= b_refl;
      c8_dg_q    <= b_dg;
      c8_ix_q    <= b_ix;
      c8_iy_q    <= b_iy;

      c9_pcx_q   <= c8_coef_q * c8_mx_q;
      c9_pcy_q   <= c8_coef_q * c8_my_q;
      c9_v1x_q   <= c8_v1x_q;
      c9_v1y_q   <= c8_v1y_q;
      c9_refl_q  <= c8_refl_q;
      c9_dg_q    <= c8_dg_q;
      c9_ix_q    <= c8_ix_q;
      c9_iy_q    <= c8_iy_q;

      c10_v2x_q  <= rrr_pkg::V2_W'(c9_v1x_q) + c10_tx_r[rrr_pkg::V2_W-1:0];
      c10_v2y_q  <= rrr_pkg::V2_W'(c9_v1y_q) + c10_ty_r[rrr_pkg::V2_W-1:0];
      c10_refl_q <= c9_refl_q;
      c10_dg_q   <= c9_dg_q;
      c10_ix_q   <= c9_ix_q;
      c10_iy_q   <= c9_iy_q;
    end
  end

  // Normalize the deflected vector.
  logic signed [UW-1:0] ux, uy;
  logic                 zo;
  logic                 e_refl, e_dg;
  logic signed [W-1:0]  e_ix, e_iy;

  rrr_norm #(.IW(rrr_pkg::V2_W)) u_norm_out (
    .clk_i  (clk_i),
    .en_i   (en),
    .x_i    (c10_v2x_q),
    .y_i    (c10_v2y_q),
    .ux_o   (ux),
    .uy_o   (uy),
    .zero_o (zo)
  );

  rrr_delay #(.WIDTH(C_W), .DEPTH(rrr_pkg::NORM_LAT)) u_dly_c (
    .clk_i (clk_i),
    .en_i  (en),
    .d_i   ({c10_refl_q, c10_dg_q, c10_ix_q, c10_iy_q}),
    .q_o   ({e_refl, e_dg, e_ix, e_iy})
  );

  // Output register: Q2.30 to Q16.16, zero-length cases handled here.
  logic signed [65:0]  ox_r, oy_r;
  logic signed [W-1:0] out_x_q, out_y_q;
  logic                refl_q, dg_q;

  assign ox_r = rrr_pkg::rsh_round(66'(ux), 14);
  assign oy_r = rrr_pkg::rsh_round(66'(uy), 14);

  always_ff @(posedge clk_i) begin
    if (en) begin
      if (e_dg) begin
        out_x_q <= e_ix;
        out_y_q <= e_iy;
        refl_q  <= 1'b0;
        dg_q    <= 1'b1;
      end else if (zo) begin
        out_x_q <= '0;
        out_y_q <= '0;
        refl_q  <= e_refl;
        dg_q    <= 1'b0;
      end else begin
        out_x_q <= ox_r[W-1:0];
        out_y_q <= oy_r[W-1:0];
        refl_q  <= e_refl;
        dg_q    <= 1'b0;
      end
    end
  end

  assign out_valid_o  = valid_q[LAT-1];
  assign out_x_o      = out_x_q;
  assign out_y_o      = out_y_q;
  assign reflected_o  = refl_q;
  assign degenerate_o = dg_q;

endmodule

// File: src/rrr_checker.sv
// Port-level checker of the refraction core, bound to the top level.
`include "ray_refract_reflect_2d_core_assert.svh"

module rrr_checker #(
  parameter int unsigned VECTOR_WIDTH = rrr_pkg::VECTOR_WIDTH_DEF
) (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           in_ready_o,
  input logic                           out_valid_o,
  input logic                           out_ready_i,
  input logic signed [VECTOR_WIDTH-1:0] out_x_o,
  input logic signed [VECTOR_WIDTH-1:0] out_y_o,
  input logic                           reflected_o,
  input logic                           degenerate_o
);

  `RRR_ASSERT(a_out_hold, out_valid_o && !out_ready_i |=> out_valid_o, "output item dropped")
  `RRR_ASSERT_HOLD(a_out_x_stable, out_valid_o && !out_ready_i, out_x_o, "stalled item changed")
  `RRR_ASSERT(a_stall_blocks_in, out_valid_o && !out_ready_i |-> !in_ready_o, "input taken in stall")
  `RRR_ASSERT(a_flags_excl, out_valid_o |-> !(degenerate_o && reflected_o), "flags both set")

endmodule

bind ray_refract_reflect_2d_core rrr_checker #(.VECTOR_WIDTH(VECTOR_WIDTH)) u_rrr_checker (.*);
